// ----- rtl/core/letter_bigram_language_scorer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the letter bigram language scorer
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef LETTER_BIGRAM_LANGUAGE_SCORER_TOP_DEFINES_SVH
`define LETTER_BIGRAM_LANGUAGE_SCORER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Assert a property on an explicit clock and active-low reset.
`define LBLS_ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbls assertion failed");
// Assert a property on the default clock and reset of the core.
`define LBLS_ASSERT(lbl, prop) `LBLS_ASSERT_AT(lbl, clk_i, rst_ni, prop)
`else
`define LBLS_ASSERT_AT(lbl, clk, rst_n, prop)
`define LBLS_ASSERT(lbl, prop)
`endif

`endif

// ----- rtl/core/lbls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbls_pkg
// Shared constants, codes and types of the letter bigram language scorer.
// ----------------------------------------------------------------------------
package lbls_pkg;

  localparam int NUM_LANGUAGES_DEF = 4;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int SCORE_WIDTH_DEF   = 32;

  localparam int OP_W       = 2;
  localparam int LANG_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int PAIR_W     = 2 * BYTE_W;
  localparam int CNT_IN_W   = 16;
  localparam int RES_SC_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Result queue; deep enough to cover the end-of-text pipeline at full rate.
  localparam int RQ_DEPTH = 8;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
  localparam logic [OP_W-1:0] OP_END   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LANGS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

  localparam logic [CFG_DATA_W-1:0] LANGS_RST = 3'd4;

  typedef struct packed {
    logic              we;
    logic [LANG_W-1:0] wlang;
    logic [PAIR_W-1:0] waddr;
    logic [CNT_IN_W-1:0] wdata;
    logic              re;
    logic [PAIR_W-1:0] raddr;
  } tbl_req_t;

  typedef struct packed {
    logic add;
    logic clear;
    logic mode;
  } acc_ctl_t;

  typedef struct packed {
    logic [LANG_W-1:0]   lang;
    logic [RES_SC_W-1:0] score;
    logic                verdict;
  } result_t;

endpackage

// ----- rtl/core/lbls_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbls channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface lbls_item_if;
  logic                          valid;
  logic                          ready;
  logic [lbls_pkg::OP_W-1:0]     opcode;
  logic [lbls_pkg::LANG_W-1:0]   table_language;
  logic [lbls_pkg::BYTE_W-1:0]   pair_first;
  logic [lbls_pkg::BYTE_W-1:0]   pair_second;
  logic [lbls_pkg::CNT_IN_W-1:0] pair_count;
  logic [lbls_pkg::BYTE_W-1:0]   text_byte;

  modport source (output valid, opcode, table_language, pair_first, pair_second,
                  pair_count, text_byte, input ready);
  modport sink (input valid, opcode, table_language, pair_first, pair_second,
                pair_count, text_byte, output ready);
endinterface

interface lbls_result_if;
  logic                          valid;
  logic                          ready;
  logic [lbls_pkg::LANG_W-1:0]   best_language;
  logic [lbls_pkg::RES_SC_W-1:0] best_score;
  logic                          verdict;

  modport source (output valid, best_language, best_score, verdict, input ready);
  modport sink (input valid, best_language, best_score, verdict, output ready);
endinterface

interface lbls_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lbls_pkg::CFG_IDX_W-1:0]  index;
  logic [lbls_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lbls_table.sv -----
`timescale 1ns / 1ps
`include "letter_bigram_language_scorer_top_defines.svh"
// ----------------------------------------------------------------------------
// lbls_table
// Banked pair-count memory, one bank per language, with clear sweep.
// ----------------------------------------------------------------------------
module lbls_table #(
  parameter int NUM_LANGUAGES = lbls_pkg::NUM_LANGUAGES_DEF,
  parameter int COUNT_WIDTH   = lbls_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  lbls_pkg::tbl_req_t                         req_i,
  output logic [NUM_LANGUAGES-1:0][COUNT_WIDTH-1:0]  rd_data_o,
  output logic                                       busy_o
);
  import lbls_pkg::*;

  localparam int PAIRS = 1 << PAIR_W;

  logic              busy_q;
  logic [PAIR_W-1:0] clr_addr_q;
  logic [COUNT_WIDTH-1:0] wdata;

  assign wdata  = COUNT_WIDTH'(req_i.wdata);
  assign busy_o = busy_q;

  // Zero one row across all banks per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {PAIR_W{1'b1}}) begin
        busy_q <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < NUM_LANGUAGES; g++) begin : gen_bank
    logic [COUNT_WIDTH-1:0] bank_mem [PAIRS];
    logic [COUNT_WIDTH-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (busy_q) begin
        bank_mem[clr_addr_q] <= '0;
      end else if (req_i.we && (32'(req_i.wlang) == g)) begin
        bank_mem[req_i.waddr] <= wdata;
      end
      if (req_i.re) begin
        rd_q <= bank_mem[req_i.raddr];
      end
    end

    assign rd_data_o[g] = rd_q;
  end

  `LBLS_ASSERT(a_tbl_idle_in_clear, busy_q |-> !(req_i.we || req_i.re))

endmodule

// ----- rtl/core/lbls_accum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbls_accum
// Per-language saturating score accumulators.
// ----------------------------------------------------------------------------
module lbls_accum #(
  parameter int NUM_LANGUAGES = lbls_pkg::NUM_LANGUAGES_DEF,
  parameter int COUNT_WIDTH   = lbls_pkg::COUNT_WIDTH_DEF,
  parameter int SCORE_WIDTH   = lbls_pkg::SCORE_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  lbls_pkg::acc_ctl_t                         ctl_i,
  input  logic [NUM_LANGUAGES-1:0]                   active_i,
  input  logic [NUM_LANGUAGES-1:0][COUNT_WIDTH-1:0]  counts_i,
  output logic [NUM_LANGUAGES-1:0][SCORE_WIDTH-1:0]  scores_o
);
  import lbls_pkg::*;

  localparam int SUM_W = ((SCORE_WIDTH > COUNT_WIDTH) ? SCORE_WIDTH : COUNT_WIDTH) + 1;
  localparam logic [SUM_W-1:0] SAT = SUM_W'({SCORE_WIDTH{1'b1}});

  for (genvar k = 0; k < NUM_LANGUAGES; k++) begin : gen_lane
    logic [COUNT_WIDTH-1:0] inc;
    logic [SUM_W-1:0]       sum;
    logic [SCORE_WIDTH-1:0] score_q;
    logic [SCORE_WIDTH-1:0] score_d;

    assign inc = ctl_i.mode ? COUNT_WIDTH'(counts_i[k] != '0) : counts_i[k];
    assign sum = SUM_W'(score_q) + SUM_W'(inc);

    always_comb begin
      score_d = score_q;
      if (ctl_i.clear) begin
        score_d = '0;
      end else if (ctl_i.add && active_i[k]) begin
        score_d = (sum > SAT) ? {SCORE_WIDTH{1'b1}} : sum[SCORE_WIDTH-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        score_q <= '0;
      end else begin
        score_q <= score_d;
      end
    end

    assign scores_o[k] = score_q;
  end

endmodule

// ----- rtl/core/lbls_argmax.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbls_argmax
// Registered compare tree picking the lowest-numbered highest score.
// ----------------------------------------------------------------------------
module lbls_argmax #(
  parameter int NUM_LANGUAGES = lbls_pkg::NUM_LANGUAGES_DEF,
  parameter int SCORE_WIDTH   = lbls_pkg::SCORE_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  input  logic [NUM_LANGUAGES-1:0]                   active_i,
  input  logic [NUM_LANGUAGES-1:0][SCORE_WIDTH-1:0]  scores_i,
  output logic                                       done_o,
  output lbls_pkg::result_t                          result_o
);
  import lbls_pkg::*;

  localparam int LVLS  = (NUM_LANGUAGES > 1) ? $clog2(NUM_LANGUAGES) : 0;
  localparam int LEAFS = 1 << LVLS;
  localparam int NODES = 2 * LEAFS - 1;
  localparam int IDX_W = (NUM_LANGUAGES > 1) ? $clog2(NUM_LANGUAGES) : 1;

  logic [SCORE_WIDTH-1:0] sc_q [NODES];
  logic [IDX_W-1:0]       ix_q [NODES];
  logic [LVLS:0]          vld_q;

  // Leaves: snapshot scores; languages not in use count as zero.
  for (genvar k = 0; k < LEAFS; k++) begin : gen_leaf
    if (k < NUM_LANGUAGES) begin : gen_used
      always_ff @(posedge clk_i) begin
        sc_q[LEAFS-1+k] <= active_i[k] ? scores_i[k] : '0;
        ix_q[LEAFS-1+k] <= IDX_W'(k);
      end
    end else begin : gen_pad
      always_ff @(posedge clk_i) begin
        sc_q[LEAFS-1+k] <= '0;
        ix_q[LEAFS-1+k] <= '0;
      end
    end
  end

  // Inner nodes: right child wins only when strictly greater.
  for (genvar i = 0; i < LEAFS - 1; i++) begin : gen_node
    always_ff @(posedge clk_i) begin
      if (sc_q[2*i+2] > sc_q[2*i+1]) begin
        sc_q[i] <= sc_q[2*i+2];
        ix_q[i] <= ix_q[2*i+2];
      end else begin
        sc_q[i] <= sc_q[2*i+1];
        ix_q[i] <= ix_q[2*i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= start_i;
      for (int l = 1; l <= LVLS; l++) begin
        vld_q[l] <= vld_q[l-1];
      end
    end
  end

  assign done_o           = vld_q[LVLS];
  assign result_o.lang    = LANG_W'(ix_q[0]);
  assign result_o.verdict = (sc_q[0] == '0);

  if (SCORE_WIDTH > RES_SC_W) begin : gen_clamp
    assign result_o.score = (|sc_q[0][SCORE_WIDTH-1:RES_SC_W]) ?
                            {RES_SC_W{1'b1}} : sc_q[0][RES_SC_W-1:0];
  end else begin : gen_ext
    assign result_o.score = RES_SC_W'(sc_q[0]);
  end

endmodule

// ----- rtl/core/lbls_resq.sv -----
`timescale 1ns / 1ps
`include "letter_bigram_language_scorer_top_defines.svh"
// ----------------------------------------------------------------------------
// lbls_resq
// Small result queue between the compare tree and the output channel.
// ----------------------------------------------------------------------------
module lbls_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lbls_pkg::result_t  push_data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output lbls_pkg::result_t  data_o
);
  import lbls_pkg::*;

  result_t             entry_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_q;
  logic [RQ_PTR_W-1:0] rd_q;
  logic [RQ_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + RQ_CNT_W'(push_i) - RQ_CNT_W'(pop_i);
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_q];

  `LBLS_ASSERT(a_rq_no_overflow, push_i |-> ((cnt_q != RQ_CNT_W'(RQ_DEPTH)) || pop_i))

endmodule

// ----- rtl/core/letter_bigram_language_scorer_top.sv -----
`timescale 1ns / 1ps
`include "letter_bigram_language_scorer_top_defines.svh"
// ----------------------------------------------------------------------------
// letter_bigram_language_scorer_top
// Byte-pair language scorer: table load, text scoring, best-language report.
// ----------------------------------------------------------------------------
// Usage:
//   item_i carries table writes, text bytes and end-of-text markers; each
//   transfer on it is one item. The user must let cfg_i write languages_in_use
//   and score_mode only while the core is idle; the core does not enforce
//   this. result_o gives one result per end-of-text item.
//   Throughput: one item per cycle while item_i.ready is high. A text byte
//   reads the pair entry of every language bank in parallel (one read port
//   per bank) and adds the counts in the next cycle; bytes stream back to back.
//   Result path: an end item passes the s1_end_q register, the leaf
//   snapshot and LVLS = ceil(log2(NUM_LANGUAGES)) compare-tree levels
//   before its result enters the result queue.
//   Reset: the pair tables are swept to zero, one pair address per cycle
//   over all banks; item_i.ready stays low until the sweep ends.
//   Register writes are taken throughout.
//   Stall: results wait in an eight-entry queue; item_i.ready drops only
//   when eight results are pending, and during the reset sweep.
// ----------------------------------------------------------------------------
module letter_bigram_language_scorer_top #(
  parameter int NUM_LANGUAGES = lbls_pkg::NUM_LANGUAGES_DEF,
  parameter int COUNT_WIDTH   = lbls_pkg::COUNT_WIDTH_DEF,
  parameter int SCORE_WIDTH   = lbls_pkg::SCORE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lbls_item_if.sink          item_i,
  lbls_cfg_if.sink           cfg_i,
  lbls_result_if.source      result_o
);
  import lbls_pkg::*;

  logic [CFG_DATA_W-1:0] langs_q;
  logic                  mode_q;
  logic [BYTE_W-1:0]     prev_q;
  logic                  have_prev_q;
  logic                  s1_add_q;
  logic                  s1_end_q;
  logic [RQ_CNT_W-1:0]   pend_q;

  logic                  item_xfer;
  logic                  end_xfer;
  logic                  res_xfer;
  logic                  tbl_busy;
  logic                  rq_push;
  logic [NUM_LANGUAGES-1:0] active;
  tbl_req_t              tbl_req;
  acc_ctl_t              acc_ctl;
  result_t               tree_res;
  result_t               rq_data;

  logic [NUM_LANGUAGES-1:0][COUNT_WIDTH-1:0] counts;
  logic [NUM_LANGUAGES-1:0][SCORE_WIDTH-1:0] scores;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = !tbl_busy && (pend_q != RQ_CNT_W'(RQ_DEPTH));
  assign item_xfer    = item_i.valid && item_i.ready;
  assign end_xfer     = item_xfer && (item_i.opcode == OP_END);
  assign res_xfer     = result_o.valid && result_o.ready;

  // Languages below the register value take part; zero acts as one.
  always_comb begin
    for (int k = 0; k < NUM_LANGUAGES; k++) begin
      active[k] = (k == 0) || (k < int'(langs_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      langs_q <= LANGS_RST;
      mode_q  <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_LANGS: langs_q <= cfg_i.data;
        CFG_MODE:  mode_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tbl_req.we    = item_xfer && (item_i.opcode == OP_WRITE);
    tbl_req.wlang = item_i.table_language;
    tbl_req.waddr = {item_i.pair_first, item_i.pair_second};
    tbl_req.wdata = item_i.pair_count;
    tbl_req.re    = item_xfer && (item_i.opcode == OP_BYTE) && have_prev_q;
    tbl_req.raddr = {prev_q, item_i.text_byte};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      s1_add_q    <= 1'b0;
      s1_end_q    <= 1'b0;
      pend_q      <= '0;
    end else begin
      s1_add_q <= tbl_req.re;
      s1_end_q <= end_xfer;
      pend_q   <= pend_q + RQ_CNT_W'(end_xfer) - RQ_CNT_W'(res_xfer);
      if (item_xfer && (item_i.opcode == OP_BYTE)) begin
        prev_q      <= item_i.text_byte;
        have_prev_q <= 1'b1;
      end else if (end_xfer) begin
        prev_q      <= '0;
        have_prev_q <= 1'b0;
      end
    end
  end

  assign acc_ctl.add   = s1_add_q;
  assign acc_ctl.clear = s1_end_q;
  assign acc_ctl.mode  = mode_q;

  lbls_table #(
    .NUM_LANGUAGES (NUM_LANGUAGES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (counts),
    .busy_o    (tbl_busy)
  );

  lbls_accum #(
    .NUM_LANGUAGES (NUM_LANGUAGES),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .SCORE_WIDTH   (SCORE_WIDTH)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (acc_ctl),
    .active_i (active),
    .counts_i (counts),
    .scores_o (scores)
  );

  lbls_argmax #(
    .NUM_LANGUAGES (NUM_LANGUAGES),
    .SCORE_WIDTH   (SCORE_WIDTH)
  ) u_argmax (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (s1_end_q),
    .active_i (active),
    .scores_i (scores),
    .done_o   (rq_push),
    .result_o (tree_res)
  );

  lbls_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rq_push),
    .push_data_i (tree_res),
    .pop_i       (res_xfer),
    .valid_o     (result_o.valid),
    .data_o      (rq_data)
  );

  assign result_o.best_language = rq_data.lang;
  assign result_o.best_score    = rq_data.score;
  assign result_o.verdict       = rq_data.verdict;

  `LBLS_ASSERT(a_pend_bound, pend_q <= RQ_CNT_W'(RQ_DEPTH))
  `LBLS_ASSERT(a_result_pending, result_o.valid |-> (pend_q != '0))
  `LBLS_ASSERT(a_byte_adds_next, tbl_req.re |=> (s1_add_q && !s1_end_q))

endmodule
